// ----- rtl/wft_pkg.sv -----
// ----------------------------------------------------------------------------
// Word frequency table package
// Shared types and constants for the word frequency table and its cells.
// ----------------------------------------------------------------------------
package wft_pkg;

  // Width of the word key on the input channel.
  localparam int KeyPortBits = 64;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;  // compare the key on the bus and register the hit
    logic bump;     // the hit cell increments its count
    logic append;   // the cell at the fill position stores the key
  } cell_ctrl_t;

endpackage

// ----- rtl/wft_if.sv -----
// ----------------------------------------------------------------------------
// Word frequency table channels
// Valid/ready channels for the word items and the result items.
// ----------------------------------------------------------------------------
interface wft_word_if;
  logic                                valid;
  logic                                ready;
  logic [wft_pkg::KeyPortBits-1:0]     word_key;

  modport source (output valid, output word_key, input ready);
  modport sink (input valid, input word_key, output ready);
endinterface

interface wft_result_if #(
  parameter int COUNT_BITS = 16,
  parameter int USED_W     = 7,
  parameter int IDX_W      = 6
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] word_count;
  logic [USED_W-1:0]     distinct_words;
  logic [COUNT_BITS-1:0] top_count;
  logic [IDX_W-1:0]      top_index;
  logic                  table_full;

  modport source (output valid, output word_count, output distinct_words,
                  output top_count, output top_index, output table_full,
                  input ready);
  modport sink (input valid, input word_count, input distinct_words,
                input top_count, input top_index, input table_full,
                output ready);
endinterface

// ----- rtl/wft_cell.sv -----
// ----------------------------------------------------------------------------
// Word frequency table cell
// Holds one word and its count, matches the broadcast key and merges its
// hit into the result chain passed on to the next cell.
// ----------------------------------------------------------------------------
module wft_cell #(
  parameter int INDEX      = 0,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 6,
  parameter int USED_W     = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wft_pkg::cell_ctrl_t    ctrl,
  input  logic [KEY_BITS-1:0]    key,
  input  logic [USED_W-1:0]      used,
  input  logic                   hit_in,
  input  logic [IDX_W-1:0]       idx_in,
  input  logic [COUNT_BITS-1:0]  cnt_in,
  output logic                   hit_out,
  output logic [IDX_W-1:0]       idx_out,
  output logic [COUNT_BITS-1:0]  cnt_out
);
  import wft_pkg::*;

  logic [KEY_BITS-1:0]   word;
  logic [COUNT_BITS-1:0] count;
  logic                  hit;
  logic                  occupied;

  // Entries at or beyond the fill count hold nothing and never match.
  assign occupied = USED_W'(INDEX) < used;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.capture) begin
      hit <= occupied && (key == word);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && (used == USED_W'(INDEX))) begin
      word  <= key;
      count <= COUNT_BITS'(1);
    end else if (ctrl.bump && hit && (count != '1)) begin
      count <= count + COUNT_BITS'(1);
    end
  end

  // Stored words are distinct, so at most one cell hits and OR merging is exact.
  assign hit_out = hit_in | hit;
  assign idx_out = idx_in | (hit ? IDX_W'(INDEX) : '0);
  assign cnt_out = cnt_in | (hit ? count : '0);

endmodule

// ----- rtl/word_frequency_table.sv -----
// ----------------------------------------------------------------------------
// Word frequency table
// Counts distinct words in a row of cells and tracks the most frequent one.
// ----------------------------------------------------------------------------
// For each word item: in the cycle it is accepted every
// cell compares the key with its stored word in parallel, and in the next
// cycle the hit is merged along the cell chain, the count is incremented or
// the word appended, and the running maximum is updated against its stored
// copy. The result goes to an output register. A new word can be accepted in
// the cycle after the update, in the same cycle that the previous result is
// taken, but a result that still waits holds back the next word. The table
// needs no clearing pass after reset: only entries below the fill count take
// part in a match.
module word_frequency_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 64,
  parameter int COUNT_BITS  = 16
) (
  input logic          clk,
  input logic          rst,
  wft_word_if.sink     word,
  wft_result_if.source result
);
  import wft_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  state_t                state, state_next;
  logic [USED_W-1:0]     used, used_next;
  logic [IDX_W-1:0]      top_pos, top_pos_next;
  logic [COUNT_BITS-1:0] top_cnt, top_cnt_next;
  logic [KEY_BITS-1:0]   key_q;
  logic [KEY_BITS-1:0]   key_bus;
  logic                  accept;
  cell_ctrl_t            ctrl;

  logic                  chain_hit [TABLE_DEPTH+1];
  logic [IDX_W-1:0]      chain_idx [TABLE_DEPTH+1];
  logic [COUNT_BITS-1:0] chain_cnt [TABLE_DEPTH+1];

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  rsp_valid;
  logic                  rsp_load;
  logic [COUNT_BITS-1:0] wc_next;
  logic                  full_next;
  logic [COUNT_BITS-1:0] rsp_wc;
  logic [USED_W-1:0]     rsp_used;
  logic [COUNT_BITS-1:0] rsp_top_cnt;
  logic [IDX_W-1:0]      rsp_top_idx;
  logic                  rsp_full;

  assign word.ready = (state == ST_IDLE) && (!rsp_valid || result.ready);
  assign accept     = word.valid && word.ready;
  assign key_bus    = accept ? word.word_key[KEY_BITS-1:0] : key_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= word.word_key[KEY_BITS-1:0];
    end
  end

  assign chain_hit[0] = 1'b0;
  assign chain_idx[0] = '0;
  assign chain_cnt[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    wft_cell #(
      .INDEX      (i),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W),
      .USED_W     (USED_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .key     (key_bus),
      .used    (used),
      .hit_in  (chain_hit[i]),
      .idx_in  (chain_idx[i]),
      .cnt_in  (chain_cnt[i]),
      .hit_out (chain_hit[i+1]),
      .idx_out (chain_idx[i+1]),
      .cnt_out (chain_cnt[i+1])
    );
  end

  assign hit     = chain_hit[TABLE_DEPTH];
  assign hit_idx = chain_idx[TABLE_DEPTH];
  assign hit_cnt = chain_cnt[TABLE_DEPTH];
  assign cnt_inc = (&hit_cnt) ? hit_cnt : hit_cnt + COUNT_BITS'(1);

  always_comb begin
    state_next   = state;
    used_next    = used;
    top_pos_next = top_pos;
    top_cnt_next = top_cnt;
    ctrl         = '0;
    ctrl.capture = accept;
    rsp_load     = 1'b0;
    wc_next      = '0;
    full_next    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
        rsp_load   = 1'b1;
        if (hit) begin
          ctrl.bump = 1'b1;
          wc_next   = cnt_inc;
          // The top entry moves only on a strictly greater count.
          if (hit_idx == top_pos) begin
            top_cnt_next = cnt_inc;
          end else if (cnt_inc > top_cnt) begin
            top_pos_next = hit_idx;
            top_cnt_next = cnt_inc;
          end
        end else if (used < USED_W'(TABLE_DEPTH)) begin
          ctrl.append = 1'b1;
          used_next   = used + USED_W'(1);
          wc_next     = COUNT_BITS'(1);
          // The first word lands at position zero, already the top position.
          if (used == '0) begin
            top_cnt_next = COUNT_BITS'(1);
          end
        end else begin
          full_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      used    <= '0;
      top_pos <= '0;
      top_cnt <= '0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      top_pos <= top_pos_next;
      top_cnt <= top_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_wc      <= wc_next;
      rsp_used    <= used_next;
      rsp_top_cnt <= top_cnt_next;
      rsp_top_idx <= top_pos_next;
      rsp_full    <= full_next;
    end
  end

  assign result.valid          = rsp_valid;
  assign result.word_count     = rsp_wc;
  assign result.distinct_words = rsp_used;
  assign result.top_count      = rsp_top_cnt;
  assign result.top_index      = rsp_top_idx;
  assign result.table_full     = rsp_full;

endmodule

// ----- rtl/wft_checker.sv -----
// ----------------------------------------------------------------------------
// Word frequency table checker
// Port-level assertions on the word frequency table, attached by bind.
// ----------------------------------------------------------------------------
module wft_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [COUNT_BITS-1:0]            word_count,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] distinct_words,
  input logic [COUNT_BITS-1:0]            top_count,
  input logic [$clog2(TABLE_DEPTH)-1:0]   top_index,
  input logic                             table_full
);
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_count)
      && $stable(distinct_words) && $stable(top_count) && $stable(top_index)
      && $stable(table_full))
    else $error("result changed while stalled");

  // One item is worked on at a time, so no item follows in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted during update");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distinct_words <= USED_W'(TABLE_DEPTH))
    else $error("distinct word count beyond table depth");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> word_count == '0
      && distinct_words == USED_W'(TABLE_DEPTH))
    else $error("word dropped while table not full");

  // A counted word never exceeds the running maximum.
  a_top_is_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_full |-> word_count != '0 && top_count >= word_count)
    else $error("running maximum below word count");

endmodule

bind word_frequency_table wft_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .COUNT_BITS  (COUNT_BITS)
) u_wft_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (word.valid),
  .in_ready       (word.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .word_count     (result.word_count),
  .distinct_words (result.distinct_words),
  .top_count      (result.top_count),
  .top_index      (result.top_index),
  .table_full     (result.table_full)
);
